>>> rtl/apt_pkg.sv
// Shared constants, types and a saturation helper for the altitude thrust controller.
`default_nettype none
package apt_pkg;

  typedef logic signed [31:0] q16_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_POS_GAIN   = 3'd0,
    REG_VEL_GAIN   = 3'd1,
    REG_INT_GAIN   = 3'd2,
    REG_ASCENT     = 3'd3,
    REG_DESCENT    = 3'd4,
    REG_MASS       = 3'd5,
    REG_TIME_STEP  = 3'd6,
    REG_UNUSED     = 3'd7
  } cfg_reg_t;

  localparam int GAIN_W = 31;
  localparam int TS_W   = 17;
  localparam int TILT_W = 18;
  localparam int INTEG_W = 48;

  // Shared multiplier operands and product.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Shared divider: dividend/quotient and divisor widths.
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 18;

  localparam logic [GAIN_W-1:0] ASCENT_RST  = 31'd6553600;
  localparam logic [GAIN_W-1:0] DESCENT_RST = 31'd6553600;
  localparam logic [GAIN_W-1:0] MASS_RST    = 31'd32768;
  localparam logic [TS_W-1:0]   TS_RST      = 17'd131;

  // 9.81 in Q16.16, rounded to nearest.
  localparam logic signed [31:0] GRAVITY_Q16 = 32'sd642908;

  function automatic q16_t sat32(input logic signed [67:0] x);
    q16_t r;
    if (x > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/apt_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module apt_mul #(
  parameter int MW = 33
) (
  input  wire logic                   clk,
  input  wire logic signed [MW-1:0]   mul_a,
  input  wire logic signed [MW-1:0]   mul_b,
  output logic signed [2*MW-1:0]      prod
);

  logic signed [2*MW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

>>> rtl/apt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module apt_div #(
  parameter int NW = 52,
  parameter int DW = 18
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      quo_r  <= dividend;
      den_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DW'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[DW-1:0];
      end
      quo_r <= {quo_r[NW-2:0], fits};
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/altitude_pid_thrust_core.sv
// Altitude PID controller top level: sequencer, configuration and state around shared units.
//
//   Channel  Direction  Handshake                Payload
//   in_      slave      in_tvalid / in_tready    in_tdata (184 b)
//   out_     master     out_tvalid / out_tready  out_tdata (32 b), out_tuser (1 b)
//   cfg_     write      cfg_wr_en                cfg_addr (3 b), cfg_wr_data (31 b)
//
// The 52-step divider sets the length of a transaction: it forms the acceleration limit
// while the shared multiplier works through the gain terms, then divides by tilt_cos;
// when tilt_cos is zero the second division is skipped.
// Reset is synchronous on rst_n and clears the integrator and the registers to defaults.
// in_tready is high only between transactions; a result waits in the output register
// and the next input is taken meanwhile; only the final step waits on out_tready.
`default_nettype none
module altitude_pid_thrust_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // alt_target, vz_target, alt_meas, vz_meas, accel_ff, tilt_cos, zero fill
  input  wire logic [183:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // thrust_cmd
  output logic [31:0]       out_tdata,
  // limited
  output logic              out_tuser,
  input  wire logic         cfg_wr_en,
  input  wire apt_pkg::cfg_reg_t cfg_addr,
  input  wire logic [apt_pkg::GAIN_W-1:0] cfg_wr_data
);
  import apt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_P, S_I0, S_VC, S_VE, S_D, S_IH, S_IL, S_IT, S_NUM,
    S_WLIM, S_WC, S_MH, S_ML, S_OUT
  } state_t;

  state_t state_r;

  logic [GAIN_W-1:0] pos_gain_r, vel_gain_r, int_gain_r, ascent_r, descent_r, mass_r;
  logic [TS_W-1:0]   ts_r;

  q16_t err_r, vz_t_r, vz_m_r, aff_r, pterm_r, vcmd_r, verr_r, dterm_r, iterm_r;
  logic signed [TILT_W-1:0]  tilt_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [35:0]        num_r;
  logic [INTEG_W-1:0]        lim_r;
  logic signed [INTEG_W-1:0] c_r;
  logic                      limited_r;
  q16_t                      out_data_r;
  logic                      out_user_r;
  logic                      out_valid_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, prod_sh;
  logic                     div_start, div_busy;
  logic [DIV_NW-1:0]        div_dividend, div_quo;
  logic [DIV_DW-1:0]        div_divisor;

  logic        in_acc;
  q16_t        in_alt_t, in_vz_t, in_alt_m, in_vz_m, in_aff;
  logic signed [TILT_W-1:0] in_tilt;
  logic [TS_W-1:0]          dt;
  logic [35:0]              num_mag;
  logic [DIV_DW-1:0]        tilt_mag;
  logic                     c_neg;
  logic signed [49:0]       isum;
  q16_t                     vsum;
  logic signed [32:0]       vs33, lo33, hi33, vc33;
  logic [INTEG_W-1:0]       lim_now;
  logic                     out_free;

  assign in_alt_t = in_tdata[31:0];
  assign in_vz_t  = in_tdata[63:32];
  assign in_alt_m = in_tdata[95:64];
  assign in_vz_m  = in_tdata[127:96];
  assign in_aff   = in_tdata[159:128];
  assign in_tilt  = in_tdata[177:160];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign dt       = (ts_r == '0) ? TS_W'(1) : ts_r;
  assign num_mag  = num_r[35] ? 36'(-num_r) : 36'(num_r);
  assign tilt_mag = tilt_r[TILT_W-1] ? DIV_DW'(-tilt_r) : DIV_DW'(tilt_r);
  assign c_neg    = num_r[35] ^ tilt_r[TILT_W-1];
  assign prod_sh  = prod >>> 16;
  assign lim_now  = div_quo[INTEG_W-1:0];

  // Integrator and velocity command paths.
  assign isum = 50'(integ_r) + signed'(prod_sh[49:0]);
  assign vsum = sat32(68'(vz_t_r) + 68'(pterm_r));
  assign vs33 = 33'(vsum);
  assign lo33 = -signed'({2'b00, ascent_r});
  assign hi33 = signed'({2'b00, descent_r});
  assign vc33 = (vs33 < lo33) ? lo33 : ((vs33 > hi33) ? hi33 : vs33);

  always_comb begin
    unique case (state_r)
      S_P: begin
        mul_a = 33'(err_r);
        mul_b = signed'({2'b00, pos_gain_r});
      end
      S_I0: begin
        mul_a = 33'(err_r);
        mul_b = signed'({16'd0, ts_r});
      end
      S_D: begin
        mul_a = 33'(verr_r);
        mul_b = signed'({2'b00, vel_gain_r});
      end
      S_IH: begin
        mul_a = 33'(signed'(integ_r[47:16]));
        mul_b = signed'({2'b00, int_gain_r});
      end
      S_IL: begin
        mul_a = signed'({17'd0, integ_r[15:0]});
        mul_b = signed'({2'b00, int_gain_r});
      end
      S_MH: begin
        mul_a = 33'(signed'(c_r[47:16]));
        mul_b = signed'({2'b00, mass_r});
      end
      // The low product is held while the result waits for the output register.
      S_ML, S_OUT: begin
        mul_a = signed'({17'd0, c_r[15:0]});
        mul_b = signed'({2'b00, mass_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = in_acc ||
                (state_r == S_WLIM && !div_busy && tilt_r != '0);
    if (state_r == S_IDLE) begin
      div_dividend = {5'd0, ascent_r, 16'd0};
      div_divisor  = {1'b0, dt};
    end else begin
      div_dividend = {num_mag, 16'd0};
      div_divisor  = tilt_mag;
    end
  end

  apt_mul #(.MW(MUL_W)) u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  apt_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gain_r <= '0;
      vel_gain_r <= '0;
      int_gain_r <= '0;
      ascent_r   <= ASCENT_RST;
      descent_r  <= DESCENT_RST;
      mass_r     <= MASS_RST;
      ts_r       <= TS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_POS_GAIN:  pos_gain_r <= cfg_wr_data;
        REG_VEL_GAIN:  vel_gain_r <= cfg_wr_data;
        REG_INT_GAIN:  int_gain_r <= cfg_wr_data;
        REG_ASCENT:    ascent_r   <= cfg_wr_data;
        REG_DESCENT:   descent_r  <= cfg_wr_data;
        REG_MASS:      mass_r     <= cfg_wr_data;
        REG_TIME_STEP: ts_r       <= cfg_wr_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            err_r   <= sat32(68'(in_alt_t) - 68'(in_alt_m));
            vz_t_r  <= in_vz_t;
            vz_m_r  <= in_vz_m;
            aff_r   <= in_aff;
            tilt_r  <= in_tilt;
            state_r <= S_P;
          end
        end
        S_P: state_r <= S_I0;
        S_I0: begin
          pterm_r <= sat32(68'(prod_sh));
          state_r <= S_VC;
        end
        S_VC: begin
          // Integrator saturates to the signed 48-bit range.
          if (isum > 50'sh7FFF_FFFF_FFFF) begin
            integ_r <= 48'sh7FFF_FFFF_FFFF;
          end else if (isum < -50'sh8000_0000_0000) begin
            integ_r <= 48'sh8000_0000_0000;
          end else begin
            integ_r <= isum[47:0];
          end
          vcmd_r  <= vc33[31:0];
          state_r <= S_VE;
        end
        S_VE: begin
          verr_r  <= sat32(68'(vcmd_r) - 68'(vz_m_r));
          state_r <= S_D;
        end
        S_D: state_r <= S_IH;
        S_IH: begin
          dterm_r <= sat32(68'(prod_sh));
          state_r <= S_IL;
        end
        S_IL: begin
          acc_r   <= prod;
          state_r <= S_IT;
        end
        S_IT: begin
          iterm_r <= sat32(68'(acc_r) + 68'(prod_sh));
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r   <= 36'(pterm_r) + 36'(dterm_r) + 36'(iterm_r) + 36'(aff_r)
                     - 36'(GRAVITY_Q16);
          state_r <= S_WLIM;
        end
        S_WLIM: begin
          if (!div_busy) begin
            lim_r <= lim_now;
            if (tilt_r == '0) begin
              // Zero tilt: the limit with num_r's sign, or zero if num_r is zero.
              limited_r <= 1'b1;
              if (num_r > 36'sd0) begin
                c_r <= signed'(lim_now);
              end else if (num_r < 36'sd0) begin
                c_r <= -signed'(lim_now);
              end else begin
                c_r <= '0;
              end
              state_r <= S_MH;
            end else begin
              state_r <= S_WC;
            end
          end
        end
        S_WC: begin
          if (!div_busy) begin
            if (div_quo > {4'd0, lim_r}) begin
              limited_r <= 1'b1;
              c_r <= c_neg ? -signed'(lim_r) : signed'(lim_r);
            end else begin
              limited_r <= 1'b0;
              c_r <= c_neg ? -signed'(div_quo[47:0]) : signed'(div_quo[47:0]);
            end
            state_r <= S_MH;
          end
        end
        S_MH: state_r <= S_ML;
        S_ML: begin
          acc_r   <= prod;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r  <= sat32(-(68'(acc_r) + 68'(prod_sh)));
            out_user_r  <= limited_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready && div_busy)
    else $error("accepted transaction did not start the limit division");

  a_accel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MH |-> (49'(c_r) <= signed'({1'b0, lim_r})) &&
                        (49'(c_r) >= -signed'({1'b0, lim_r})))
    else $error("acceleration command outside the limit");

endmodule
`default_nettype wire
